// ----- hw/rtl/utf8_bmp_decoder_unit_macros.svh -----
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_BMP_DECODER_UNIT_MACROS_SVH
`define UTF8_BMP_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define UBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define UBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

// ----- hw/rtl/ubd_pkg.sv -----
// Shared types and constants of the UTF-8 to BMP decoder.
package ubd_pkg;

  localparam int MAX_RESULTS = 3;

  localparam logic [15:0] ERR_CP          = 16'h003F;
  localparam logic [15:0] MAX_CHARS_RESET = 16'd255;

  // Number of bytes held for an unfinished sequence.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_LEAD = 2'd1;
  localparam logic [1:0] PEND_CONT = 2'd2;

  typedef struct packed {
    logic [15:0] code_point;
    logic        is_error;
    logic        string_end;
  } ubd_result_t;

  typedef ubd_result_t [MAX_RESULTS-1:0] ubd_result_list_t;

endpackage

// ----- hw/rtl/ubd_skid.sv -----
// Input skid stage: keeps the upstream ready signal registered.
module ubd_skid
  import ubd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);

  logic       buf_valid;
  logic [7:0] buf_byte;

  assign s_tready  = !buf_valid;
  assign out_valid = buf_valid || s_tvalid;
  assign out_byte  = buf_valid ? buf_byte : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (buf_valid) begin
      if (out_ready) begin
        buf_valid <= 1'b0;
      end
    end else if (s_tvalid && !out_ready) begin
      buf_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!buf_valid && s_tvalid && !out_ready) begin
      buf_byte <= s_tdata;
    end
  end

endmodule

// ----- hw/rtl/ubd_decode.sv -----
// Sequence state and single-pass decode of one byte into up to three results.
module ubd_decode
  import ubd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       in_byte,
  input  logic [15:0]      max_chars,
  output ubd_result_list_t res,
  output logic [1:0]       res_count
);

  logic [7:0]  lead_byte, lead_byte_next;
  logic [7:0]  first_cont, first_cont_next;
  logic [1:0]  pending_count, pending_count_next;
  logic [15:0] emitted_count, emitted_count_next;

  ubd_result_t      cand [MAX_RESULTS];
  ubd_result_t      err_res;
  ubd_result_t      end_res;
  ubd_result_t      fresh_res;
  logic [1:0]       ncand;
  logic [1:0]       nkeep;
  logic [16:0]      room;
  logic             is_zero;
  logic             is_cont;
  logic             fresh_lead;
  logic [15:0]      cp2;
  logic [15:0]      cp3;

  assign is_zero    = (in_byte == 8'h00);
  assign is_cont    = (in_byte[7:6] == 2'b10);
  assign fresh_lead = (in_byte[7:5] == 3'b110) || (in_byte[7:4] == 4'b1110);
  assign err_res    = '{code_point: ERR_CP, is_error: 1'b1, string_end: 1'b0};
  assign end_res    = '{code_point: 16'h0000, is_error: 1'b0, string_end: 1'b1};
  // A fresh byte that is not a lead: ASCII passes, anything else is a stray byte.
  assign fresh_res  = in_byte[7] ? err_res
                    : '{code_point: {8'h00, in_byte}, is_error: 1'b0, string_end: 1'b0};
  assign cp2 = {5'b00000, lead_byte[4:0], in_byte[5:0]};
  assign cp3 = {lead_byte[3:0], first_cont[5:0], in_byte[5:0]};

  always_comb begin
    cand[0] = err_res;
    cand[1] = err_res;
    cand[2] = err_res;
    ncand   = 2'd0;
    lead_byte_next     = lead_byte;
    first_cont_next    = first_cont;
    pending_count_next = PEND_NONE;
    if (is_zero) begin
      lead_byte_next  = 8'h00;
      first_cont_next = 8'h00;
      case (pending_count)
        PEND_LEAD: ncand = 2'd1;
        PEND_CONT: ncand = 2'd2;
        default:   ncand = 2'd0;
      endcase
    end else begin
      case (pending_count)
        PEND_LEAD: begin
          if (is_cont) begin
            if (lead_byte[7:5] == 3'b110) begin
              // Values below 0x80 are overlong two-byte forms.
              if (lead_byte[4:1] != 4'd0) begin
                cand[0] = '{code_point: cp2, is_error: 1'b0, string_end: 1'b0};
              end
              ncand = 2'd1;
            end else begin
              first_cont_next    = in_byte;
              pending_count_next = PEND_CONT;
            end
          end else begin
            cand[1] = fresh_res;
            ncand   = fresh_lead ? 2'd1 : 2'd2;
          end
        end
        PEND_CONT: begin
          if (is_cont) begin
            // Values below 0x800 are overlong three-byte forms.
            if ((lead_byte[3:0] != 4'd0) || first_cont[5]) begin
              cand[0] = '{code_point: cp3, is_error: 1'b0, string_end: 1'b0};
            end
            ncand = 2'd1;
          end else begin
            cand[2] = fresh_res;
            ncand   = fresh_lead ? 2'd2 : 2'd3;
          end
        end
        default: begin
          cand[0] = fresh_res;
          ncand   = fresh_lead ? 2'd0 : 2'd1;
        end
      endcase
      if (fresh_lead && !(is_cont && pending_count != PEND_NONE
                          && pending_count != 2'd3)) begin
        lead_byte_next     = in_byte;
        first_cont_next    = 8'h00;
        pending_count_next = PEND_LEAD;
      end
    end
  end

  // Character results beyond the limit are dropped; the end mark never is.
  assign room = {1'b0, max_chars} - {1'b0, emitted_count};

  always_comb begin
    if (emitted_count >= max_chars) begin
      nkeep = 2'd0;
    end else if (room >= {15'd0, ncand}) begin
      nkeep = ncand;
    end else begin
      nkeep = room[1:0];
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = (i < int'(nkeep)) ? cand[i] : end_res;
    end
    res_count          = nkeep + {1'b0, is_zero};
    emitted_count_next = is_zero ? 16'd0 : emitted_count + {14'd0, nkeep};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte     <= 8'h00;
      first_cont    <= 8'h00;
      pending_count <= PEND_NONE;
      emitted_count <= 16'd0;
    end else if (take) begin
      lead_byte     <= lead_byte_next;
      first_cont    <= first_cont_next;
      pending_count <= pending_count_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule

// ----- hw/rtl/ubd_result.sv -----
// Result register: holds the results of one byte and sends them one beat at a time.
module ubd_result
  import ubd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ubd_result_list_t res,
  input  logic [1:0]       res_count,
  output logic             load_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // code_point
  output logic             m_tuser,   // is_error
  output logic             m_tlast    // string_end
);

  ubd_result_list_t entries;
  logic [1:0]       remaining;
  logic [1:0]       idx;
  ubd_result_t      head;

  assign m_tvalid   = (remaining != 2'd0);
  assign load_ready = (remaining == 2'd0) || (m_tready && remaining == 2'd1);

  always_comb begin
    case (idx)
      2'd0:    head = entries[0];
      2'd1:    head = entries[1];
      default: head = entries[2];
    endcase
  end

  assign m_tdata = head.code_point;
  assign m_tuser = head.is_error;
  assign m_tlast = head.string_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      idx       <= 2'd0;
    end else if (load) begin
      remaining <= res_count;
      idx       <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      remaining <= remaining - 2'd1;
      idx       <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= res;
    end
  end

endmodule

// ----- hw/rtl/utf8_bmp_decoder_unit.sv -----
// UTF-8 to BMP decoder: top level joining skid stage, decoder and result register.
//
// Input stream s_*: one UTF-8 byte per beat; a zero byte ends the string.
// Output stream m_*: one result per beat, code point in tdata, tuser set for
// a malformed sequence (code point '?'), tlast set on the end mark that
// follows every zero byte. A byte gives zero to three results.
// Configuration: cfg_data writes the character limit per string; cfg_ready is
// always high and the new limit applies to the next byte decoded.
// A byte's results are registered in the result register before they reach m_*.
// Throughput: one byte per cycle when each byte gives at most one result and
// m_tready is high; a byte with more results holds the input until the single
// output port drains the result register, one entry per cycle with m_tready high.
// Stalls: s_tready comes from a flop of the input skid stage, so a stalled
// receiver backs up through the result register and skid entry without any
// combinational path from m_tready to s_tready.
// Reset: rst clears any pending sequence, the character count and the
// result register, and sets the limit to 255.
module utf8_bmp_decoder_unit
  import ubd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // code_point
  output logic        m_tuser,    // is_error
  output logic        m_tlast,    // string_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // max_chars
);

  `include "utf8_bmp_decoder_unit_macros.svh"

  logic             dec_valid;
  logic [7:0]       dec_byte;
  logic             res_ready;
  logic             take;
  ubd_result_list_t res;
  logic [1:0]       res_count;
  logic [15:0]      max_chars;

  assign cfg_ready = 1'b1;
  assign take      = dec_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= MAX_CHARS_RESET;
    end else if (cfg_valid) begin
      max_chars <= cfg_data;
    end
  end

  ubd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .out_valid (dec_valid),
    .out_ready (res_ready),
    .out_byte  (dec_byte)
  );

  ubd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (dec_byte),
    .max_chars (max_chars),
    .res       (res),
    .res_count (res_count)
  );

  ubd_result u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .res        (res),
    .res_count  (res_count),
    .load_ready (res_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // The end mark carries a zero code point and no error flag.
  `UBD_ASSERT_NOW(a_end_mark_clean, m_tvalid && m_tlast, m_tdata == 16'h0000 && !m_tuser)
  // An error beat always carries the replacement character.
  `UBD_ASSERT_NOW(a_error_is_replacement, m_tvalid && m_tuser, m_tdata == ERR_CP)
  // A zero byte always produces a list whose last entry is the end mark.
  `UBD_ASSERT_NOW(a_zero_ends_list, take && dec_byte == 8'h00,
                  (res_count == 2'd1 && res[0].string_end) ||
                  (res_count == 2'd2 && res[1].string_end) ||
                  (res_count == 2'd3 && res[2].string_end))
  // Once a byte is taken with results, the first one is offered next cycle.
  `UBD_ASSERT_NEXT(a_results_offered, take && res_count != 2'd0, m_tvalid)

endmodule
